// ----- hdl/cpfm_pkg.sv -----
// cpfm_pkg: shared widths and register indexes for the capture pair frequency meter
// no dependencies; imported by every module of the block
package cpfm_pkg;

    localparam int CAP_W      = 16;
    localparam int FREQ_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int PRESC_W    = 16;
    localparam int CPS_W      = 2;

    // divisor multiplier: (prescaler + 1) << both_edges
    localparam int M_W   = PRESC_W + 2;
    // numerator: clock_hz << capture_prescale_log2
    localparam int NUM_W = FREQ_W + 3;

    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_PSC    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTH_EDGES = 2'd3;

    localparam logic [FREQ_W-1:0] CLOCK_HZ_RESET = 32'd64000000;

endpackage

// ----- hdl/capture_pair_frequency_meter_unit.sv -----
// capture_pair_frequency_meter_unit: top level, capture pairing, config registers, sequencing
// depends on cpfm_pkg, cpfm_mul, cpfm_div
//
//   channel   direction   handshake            payload
//   in        input       in_valid / in_stall   capture_value
//   out       output      out_valid / out_stall frequency_hz, equal_error
//   cfg       input       cfg_we                cfg_index, cfg_data
//
// a first capture is stored at its accepting edge and gives no item
// a second capture: the serial multiplier forms the divisor, then the divider is started,
// the serial divider forms the quotient one bit at a time, the result leaves it and the output is loaded:
// only then is the item valid, and the next capture is taken after that
// equal captures skip the arithmetic and go straight to the final load, which gives an error item
// one item at a time; a waiting output item stalls only the final load
// reset brings config registers to their defaults and clears the pending capture
module capture_pair_frequency_meter_unit #(
    parameter longint unsigned COUNTER_MAX = 64'd65535
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [cpfm_pkg::CAP_W-1:0]        capture_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [cpfm_pkg::FREQ_W-1:0]       frequency_hz,
    output logic                              equal_error,
    input  logic                              cfg_we,
    input  logic [cpfm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cpfm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cpfm_pkg::*;

    localparam int DIFF_W = $clog2(COUNTER_MAX + 64'd1);
    localparam int DEN_W  = DIFF_W + M_W;
    localparam logic [CAP_W-1:0] CAP_TOP =
        (COUNTER_MAX > 64'd65535) ? {CAP_W{1'b1}} : CAP_W'(COUNTER_MAX);
    localparam logic [DIFF_W-1:0] CMAX_D = DIFF_W'(COUNTER_MAX);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [FREQ_W-1:0]   clock_hz_reg;
    logic [PRESC_W-1:0]  presc_reg;
    logic [CPS_W-1:0]    cps_reg;
    logic                both_reg;
    logic                pending_reg, pending_next;
    logic [CAP_W-1:0]    first_reg, first_next;
    logic                err_reg, err_next;
    logic                out_valid_reg, out_valid_next;
    logic [FREQ_W-1:0]   freq_reg, freq_next;
    logic                eqerr_reg, eqerr_next;

    logic                in_acc;
    logic [CAP_W-1:0]    v1, v2;
    logic [DIFF_W-1:0]   v1d, v2d, diff;
    logic [PRESC_W:0]    presc_inc;
    logic [M_W-1:0]      mult;
    logic [NUM_W-1:0]    num;
    logic                mul_start, mul_done;
    logic [DEN_W-1:0]    product;
    logic                div_start, div_done;
    logic [FREQ_W-1:0]   quot;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;

    assign v1   = (first_reg > CAP_TOP) ? CAP_TOP : first_reg;
    assign v2   = (capture_value > CAP_TOP) ? CAP_TOP : capture_value;
    assign v1d  = DIFF_W'(v1);
    assign v2d  = DIFF_W'(v2);
    assign diff = (v2 > v1) ? (v2d - v1d) : (CMAX_D - v1d + v2d + DIFF_W'(1));

    assign presc_inc = {1'b0, presc_reg} + (PRESC_W+1)'(1);
    assign mult      = both_reg ? {presc_inc, 1'b0} : {1'b0, presc_inc};
    assign num       = NUM_W'(clock_hz_reg) << cps_reg;

    always_comb
    begin
        state_next     = state_reg;
        pending_next   = pending_reg;
        first_next     = first_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        freq_next      = freq_reg;
        eqerr_next     = eqerr_reg;
        mul_start      = 1'b0;
        div_start      = 1'b0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (!pending_reg)
                    begin
                        pending_next = 1'b1;
                        first_next   = capture_value;
                    end
                    else
                    begin
                        pending_next = 1'b0;
                        if (v1 == v2)
                        begin
                            err_next   = 1'b1;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            err_next   = 1'b0;
                            mul_start  = 1'b1;
                            state_next = ST_MUL;
                        end
                    end
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    freq_next      = err_reg ? '0 : quot;
                    eqerr_next     = err_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pending_reg   <= 1'b0;
            first_reg     <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            clock_hz_reg  <= CLOCK_HZ_RESET;
            presc_reg     <= '0;
            cps_reg       <= '0;
            both_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pending_reg   <= pending_next;
            first_reg     <= first_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CLOCK_HZ:   clock_hz_reg <= cfg_data[FREQ_W-1:0];
                    CFG_PRESCALER:  presc_reg    <= cfg_data[PRESC_W-1:0];
                    CFG_CAP_PSC:    cps_reg      <= cfg_data[CPS_W-1:0];
                    CFG_BOTH_EDGES: both_reg     <= cfg_data[0];
                    default:        both_reg     <= both_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        freq_reg  <= freq_next;
        eqerr_reg <= eqerr_next;
    end

    cpfm_mul #(
        .DIFF_W (DIFF_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .diff    (diff),
        .mult    (mult),
        .done    (mul_done),
        .product (product)
    );

    cpfm_div #(
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num),
        .den   (product),
        .done  (div_done),
        .quot  (quot)
    );

    assign out_valid    = out_valid_reg;
    assign frequency_hz = freq_reg;
    assign equal_error  = eqerr_reg;

endmodule

// ----- hdl/cpfm_mul.sv -----
// cpfm_mul: bit-serial shift-add multiplier, one multiplier bit per cycle, msb first
// depends on cpfm_pkg
module cpfm_mul #(
    parameter int DIFF_W = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [DIFF_W-1:0]                 diff,
    input  logic [cpfm_pkg::M_W-1:0]          mult,
    output logic                              done,
    output logic [DIFF_W+cpfm_pkg::M_W-1:0]   product
);
    import cpfm_pkg::*;

    localparam int DEN_W = DIFF_W + M_W;
    localparam int CNT_W = $clog2(M_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DEN_W-1:0]    acc_reg, acc_next;
    logic [M_W-1:0]      m_reg, m_next;
    logic [DIFF_W-1:0]   diff_reg, diff_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        m_next    = m_reg;
        diff_next = diff_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(M_W - 1);
            acc_next  = '0;
            m_next    = mult;
            diff_next = diff;
        end
        else if (busy_reg)
        begin
            acc_next = {acc_reg[DEN_W-2:0], 1'b0}
                     + (m_reg[M_W-1] ? DEN_W'(diff_reg) : '0);
            m_next   = {m_reg[M_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        m_reg    <= m_next;
        diff_reg <= diff_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ----- hdl/cpfm_div.sv -----
// cpfm_div: restoring divider, one quotient bit per cycle, saturating 32-bit quotient
// depends on cpfm_pkg
module cpfm_div #(
    parameter int DEN_W = 34
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cpfm_pkg::NUM_W-1:0]    num,
    input  logic [DEN_W-1:0]              den,
    output logic                          done,
    output logic [cpfm_pkg::FREQ_W-1:0]   quot
);
    import cpfm_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DEN_W-1:0]   rem_reg, rem_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [NUM_W-1:0]   numq_reg, numq_next;
    logic [DEN_W:0]     cand;
    logic [DEN_W:0]     diffc;
    logic               ge;

    assign cand  = {rem_reg, numq_reg[NUM_W-1]};
    assign ge    = cand >= {1'b0, den_reg};
    assign diffc = cand - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        numq_next = numq_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W - 1);
            rem_next  = '0;
            den_next  = den;
            numq_next = num;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diffc[DEN_W-1:0] : cand[DEN_W-1:0];
            numq_next = {numq_reg[NUM_W-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        numq_reg <= numq_next;
    end

    // saturate when the quotient needs more than 32 bits
    assign done = done_reg;
    assign quot = (|numq_reg[NUM_W-1:FREQ_W]) ? '1 : numq_reg[FREQ_W-1:0];

endmodule

// ----- hdl/cpfm_chk.sv -----
// cpfm_chk: port-level checks for the capture pair frequency meter, bound to the top level
// depends on cpfm_pkg and capture_pair_frequency_meter_unit
module cpfm_chk (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [cpfm_pkg::FREQ_W-1:0]   frequency_hz,
    input  logic                          equal_error
);
    import cpfm_pkg::*;

    // a stalled item stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(frequency_hz) && $stable(equal_error))
        else $error("output item changed while stalled");

    // an error item carries no frequency
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && equal_error |-> frequency_hz == '0)
        else $error("error item with nonzero frequency");

    // a new item is loaded only while the input side is busy
    a_busy_before: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("output item appeared without a busy input side");

endmodule

bind capture_pair_frequency_meter_unit cpfm_chk u_cpfm_chk (.*);
